/* rtl/bfca_pkg.sv */
// types and codes shared by the best-fit allocator controller, datapath and checker
// no dependencies
`timescale 1ns / 1ps

package bfca_pkg;

    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FIT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_RD,
        S_A_CHK,
        S_REST,
        S_G_RD,
        S_G_CHK,
        S_G_DEC,
        S_NEXT,
        S_D_RD,
        S_D_WR,
        S_I_INIT,
        S_I_RD,
        S_I_CHK,
        S_I_WR,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        DK_ALLOC,
        DK_PREV,
        DK_NEXT
    } drop_kind_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_READ_CUR,
        OP_READ_UP,
        OP_READ_DN,
        OP_A_TAKE,
        OP_IDX_INC,
        OP_A_REST,
        OP_NOFIT,
        OP_FULL,
        OP_G_CHK,
        OP_PREP_PREV,
        OP_PREP_NEXT,
        OP_D_WR,
        OP_D_END,
        OP_INS_INIT,
        OP_I_MOVE,
        OP_I_WR
    } op_t;

    typedef struct packed {
        logic idx_lt_cnt;
        logic up_lt_cnt;
        logic idx_nz;
        logic fit;
        logic greater;
        logic both_found;
        logic has_prev;
        logic has_next;
        logic full;
        logic rest_nz;
    } dp_status_t;

endpackage

/* rtl/bfca_ctrl.sv */
// request sequencer: scan, drop, merge and sorted insert steps
// depends on bfca_pkg
`timescale 1ns / 1ps

module bfca_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               req_type,
    input  bfca_pkg::dp_status_t st,
    output bfca_pkg::op_t      op,
    output logic               busy,
    output logic               done
);
    import bfca_pkg::*;

    state_t     state_reg, state_next;
    drop_kind_t dk_reg, dk_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            dk_reg    <= DK_ALLOC;
        end
        else
        begin
            state_reg <= state_next;
            dk_reg    <= dk_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        dk_next    = dk_reg;
        op         = OP_NONE;
        busy       = (state_reg != S_IDLE);
        done       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op         = OP_LOAD;
                    state_next = (req_type == REQ_ALLOC) ? S_A_RD : S_G_RD;
                end
            end
            S_A_RD:
            begin
                if (st.idx_lt_cnt)
                begin
                    op         = OP_READ_CUR;
                    state_next = S_A_CHK;
                end
                else
                begin
                    op         = OP_NOFIT;
                    state_next = S_DONE;
                end
            end
            S_A_CHK:
            begin
                if (st.fit)
                begin
                    op         = OP_A_TAKE;
                    dk_next    = DK_ALLOC;
                    state_next = S_D_RD;
                end
                else
                begin
                    op         = OP_IDX_INC;
                    state_next = S_A_RD;
                end
            end
            S_REST:
            begin
                op         = OP_A_REST;
                state_next = S_G_RD;
            end
            S_G_RD:
            begin
                if (st.idx_lt_cnt)
                begin
                    op         = OP_READ_CUR;
                    state_next = S_G_CHK;
                end
                else
                begin
                    state_next = S_G_DEC;
                end
            end
            S_G_CHK:
            begin
                op         = OP_G_CHK;
                state_next = st.both_found ? S_G_DEC : S_G_RD;
            end
            S_G_DEC:
            begin
                priority if (!st.has_prev && !st.has_next && st.full)
                begin
                    op         = OP_FULL;
                    state_next = S_DONE;
                end
                else if (st.has_prev)
                begin
                    op         = OP_PREP_PREV;
                    dk_next    = DK_PREV;
                    state_next = S_D_RD;
                end
                else if (st.has_next)
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    state_next = S_I_INIT;
                end
            end
            S_NEXT:
            begin
                op         = OP_PREP_NEXT;
                dk_next    = DK_NEXT;
                state_next = S_D_RD;
            end
            S_D_RD:
            begin
                if (st.up_lt_cnt)
                begin
                    op         = OP_READ_UP;
                    state_next = S_D_WR;
                end
                else
                begin
                    op = OP_D_END;
                    unique case (dk_reg)
                        DK_ALLOC: state_next = st.rest_nz ? S_REST : S_DONE;
                        DK_PREV:  state_next = st.has_next ? S_NEXT : S_I_INIT;
                        DK_NEXT:  state_next = S_I_INIT;
                        default:  state_next = S_DONE;
                    endcase
                end
            end
            S_D_WR:
            begin
                op         = OP_D_WR;
                state_next = S_D_RD;
            end
            S_I_INIT:
            begin
                op         = OP_INS_INIT;
                state_next = S_I_RD;
            end
            S_I_RD:
            begin
                if (st.idx_nz)
                begin
                    op         = OP_READ_DN;
                    state_next = S_I_CHK;
                end
                else
                begin
                    state_next = S_I_WR;
                end
            end
            S_I_CHK:
            begin
                if (st.greater)
                begin
                    op         = OP_I_MOVE;
                    state_next = S_I_RD;
                end
                else
                begin
                    state_next = S_I_WR;
                end
            end
            S_I_WR:
            begin
                op         = OP_I_WR;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/bfca_dp.sv */
// free table memory, working registers and compares of the allocator
// depends on bfca_pkg
`timescale 1ns / 1ps

module bfca_dp #(
    parameter int TABLE_ENTRIES = 16,
    parameter int ADDR_WIDTH    = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bfca_pkg::op_t                     op,
    input  logic [bfca_pkg::DATA_W-1:0]       req_size,
    input  logic [bfca_pkg::DATA_W-1:0]       req_offset,
    output bfca_pkg::dp_status_t              st,
    output logic [bfca_pkg::STATUS_W-1:0]     status,
    output logic [bfca_pkg::DATA_W-1:0]       alloc_offset,
    output logic [bfca_pkg::COUNT_W-1:0]      free_blocks
);
    import bfca_pkg::*;

    localparam int AW  = ADDR_WIDTH;
    localparam int AI  = $clog2(TABLE_ENTRIES);
    localparam int IW  = $clog2(TABLE_ENTRIES + 1);
    localparam logic [IW-1:0] FULL_CNT = IW'(TABLE_ENTRIES);

    logic [AW-1:0] mem_off  [TABLE_ENTRIES];
    logic [AW-1:0] mem_size [TABLE_ENTRIES];

    logic [AW-1:0] rd_off_reg, rd_size_reg;
    logic [AW-1:0] off_reg, sz_reg;
    logic [AW-1:0] prev_off_reg, prev_size_reg, next_size_reg;
    logic [AI-1:0] prev_idx_reg, next_idx_reg;
    logic          has_prev_reg, has_next_reg;
    logic [IW-1:0] idx_reg, cnt_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [AW-1:0] aoff_reg;

    logic [AW-1:0] end_addr, rd_end;
    logic          hit_prev, hit_next;
    logic [IW:0]   idx_up;
    logic [AI-1:0] rd_addr, wr_addr;
    logic          rd_en;

    assign end_addr = off_reg + sz_reg;
    assign rd_end   = rd_off_reg + rd_size_reg;
    assign hit_prev = (rd_end == off_reg);
    assign hit_next = !hit_prev && (rd_off_reg == end_addr);
    assign idx_up   = {1'b0, idx_reg} + 1'b1;
    assign wr_addr  = idx_reg[AI-1:0];

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = idx_reg[AI-1:0];
        unique case (op)
            OP_READ_CUR:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_reg[AI-1:0];
            end
            OP_READ_UP:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_up[AI-1:0];
            end
            OP_READ_DN:
            begin
                rd_en   = 1'b1;
                rd_addr = AI'(idx_reg - 1'b1);
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_off_reg  <= mem_off[rd_addr];
            rd_size_reg <= mem_size[rd_addr];
        end
        if (op == OP_D_WR || op == OP_I_MOVE)
        begin
            mem_off[wr_addr]  <= rd_off_reg;
            mem_size[wr_addr] <= rd_size_reg;
        end
        else if (op == OP_I_WR)
        begin
            mem_off[wr_addr]  <= off_reg;
            mem_size[wr_addr] <= sz_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            idx_reg      <= '0;
            has_prev_reg <= 1'b0;
            has_next_reg <= 1'b0;
            status_reg   <= ST_OK;
        end
        else
        begin
            unique case (op)
                OP_LOAD:
                begin
                    idx_reg      <= '0;
                    has_prev_reg <= 1'b0;
                    has_next_reg <= 1'b0;
                    status_reg   <= ST_OK;
                end
                OP_IDX_INC:  idx_reg <= IW'(idx_up);
                OP_A_REST:
                begin
                    idx_reg      <= '0;
                    has_prev_reg <= 1'b0;
                    has_next_reg <= 1'b0;
                end
                OP_NOFIT:    status_reg <= ST_NO_FIT;
                OP_FULL:     status_reg <= ST_FULL;
                OP_G_CHK:
                begin
                    idx_reg <= IW'(idx_up);
                    if (hit_prev)
                    begin
                        has_prev_reg <= 1'b1;
                    end
                    if (hit_next)
                    begin
                        has_next_reg <= 1'b1;
                    end
                end
                OP_PREP_PREV: idx_reg <= IW'(prev_idx_reg);
                OP_PREP_NEXT:
                begin
                    if (has_prev_reg && (prev_idx_reg < next_idx_reg))
                    begin
                        idx_reg <= IW'(next_idx_reg) - 1'b1;
                    end
                    else
                    begin
                        idx_reg <= IW'(next_idx_reg);
                    end
                end
                OP_D_WR:     idx_reg <= IW'(idx_up);
                OP_D_END:    cnt_reg <= cnt_reg - 1'b1;
                OP_INS_INIT: idx_reg <= cnt_reg;
                OP_I_MOVE:   idx_reg <= idx_reg - 1'b1;
                OP_I_WR:     cnt_reg <= cnt_reg + 1'b1;
                default:
                begin
                end
            endcase
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        unique case (op)
            OP_LOAD:
            begin
                sz_reg   <= AW'(req_size);
                off_reg  <= AW'(req_offset);
                aoff_reg <= '0;
            end
            OP_A_TAKE:
            begin
                prev_off_reg  <= rd_off_reg;
                prev_size_reg <= rd_size_reg;
                aoff_reg      <= rd_off_reg;
            end
            OP_A_REST:
            begin
                off_reg <= prev_off_reg + sz_reg;
                sz_reg  <= prev_size_reg - sz_reg;
            end
            OP_G_CHK:
            begin
                if (hit_prev)
                begin
                    prev_idx_reg  <= idx_reg[AI-1:0];
                    prev_off_reg  <= rd_off_reg;
                    prev_size_reg <= rd_size_reg;
                end
                if (hit_next)
                begin
                    next_idx_reg  <= idx_reg[AI-1:0];
                    next_size_reg <= rd_size_reg;
                end
            end
            OP_PREP_PREV:
            begin
                off_reg <= prev_off_reg;
                sz_reg  <= sz_reg + prev_size_reg;
            end
            OP_PREP_NEXT: sz_reg <= sz_reg + next_size_reg;
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        st.idx_lt_cnt = (idx_reg < cnt_reg);
        st.up_lt_cnt  = (idx_up < {1'b0, cnt_reg});
        st.idx_nz     = (idx_reg != '0);
        st.fit        = (rd_size_reg >= sz_reg);
        st.greater    = (rd_size_reg > sz_reg);
        st.both_found = (has_prev_reg || hit_prev) && (has_next_reg || hit_next);
        st.has_prev   = has_prev_reg;
        st.has_next   = has_next_reg;
        st.full       = (cnt_reg >= FULL_CNT);
        st.rest_nz    = (prev_size_reg != sz_reg);
    end

    assign status       = status_reg;
    assign alloc_offset = DATA_W'(aoff_reg);
    assign free_blocks  = COUNT_W'(cnt_reg);

endmodule

/* rtl/best_fit_coalescing_allocator.sv */
// best-fit free-block allocator with coalescing, top level
// depends on bfca_pkg, bfca_ctrl, bfca_dp
//
// channel  | handshake        | fields
// request  | start / busy     | req_type, req_size, req_offset
// result   | done (one cycle) | status, alloc_offset, free_blocks
//
// a request visits table entries one at a time, since the scans and shifts go through
// the single read port of the table memory
// the longest request is an allocate whose remainder merges on both sides
// reset empties the table at once, no clearing pass
// done is high for one cycle and busy stays high through it; results cannot be stalled
`timescale 1ns / 1ps

module best_fit_coalescing_allocator #(
    parameter int TABLE_ENTRIES = 16,
    parameter int ADDR_WIDTH    = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          req_type,
    input  logic [bfca_pkg::DATA_W-1:0]   req_size,
    input  logic [bfca_pkg::DATA_W-1:0]   req_offset,
    output logic                          done,
    output logic [bfca_pkg::STATUS_W-1:0] status,
    output logic [bfca_pkg::DATA_W-1:0]   alloc_offset,
    output logic [bfca_pkg::COUNT_W-1:0]  free_blocks
);
    import bfca_pkg::*;

    op_t        op;
    dp_status_t st;

    bfca_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .st       (st),
        .op       (op),
        .busy     (busy),
        .done     (done)
    );

    bfca_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .ADDR_WIDTH    (ADDR_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .req_size     (req_size),
        .req_offset   (req_offset),
        .st           (st),
        .status       (status),
        .alloc_offset (alloc_offset),
        .free_blocks  (free_blocks)
    );

endmodule

/* rtl/bfca_checker.sv */
// port-level checks for the allocator, bound to the top level
// depends on bfca_pkg
`timescale 1ns / 1ps

module bfca_props (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic [bfca_pkg::STATUS_W-1:0] status,
    input logic [bfca_pkg::DATA_W-1:0]   alloc_offset
);
    import bfca_pkg::*;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request accepted but block not busy");

    a_done_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done outside a request");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("done longer than one cycle");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != ST_OK) |-> (alloc_offset == '0) &&
            (status == ST_NO_FIT || status == ST_FULL))
        else $error("bad status or nonzero offset on failure");

endmodule

bind best_fit_coalescing_allocator bfca_props u_bfca_props (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .alloc_offset (alloc_offset)
);
